FILE: src/rff_pkg.sv
// ----------------------------------------------------------------------------
// rff_pkg: shared definitions of the radial force field
// Default coordinate width and the register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package rff_pkg;

  // Width of coordinates, the field centre, the peak force and the results.
  localparam int unsigned COORD_WIDTH = 32;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_PEAK_FORCE = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: src/rff_if.sv
// ----------------------------------------------------------------------------
// rff_if: channel interfaces of the radial force field
// Particle position channel and force result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rff_pos_if #(
  parameter int unsigned W = rff_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] particle_x;
  logic signed [W-1:0] particle_y;
  logic signed [W-1:0] particle_z;

  modport source (output valid, particle_x, particle_y, particle_z, input ready);
  modport sink   (input valid, particle_x, particle_y, particle_z, output ready);
endinterface

interface rff_force_if #(
  parameter int unsigned W = rff_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] force_x;
  logic signed [W-1:0] force_y;
  logic signed [W-1:0] force_z;
  logic                inside_res;

  modport source (output valid, force_x, force_y, force_z, inside_res, input ready);
  modport sink   (input valid, force_x, force_y, force_z, inside_res, output ready);
endinterface

`default_nettype wire

FILE: src/rff_sqrt.sv
// ----------------------------------------------------------------------------
// rff_sqrt: pipelined integer square root
// One result bit per stage, floor of the root, with a sideband that travels
// alongside the operand.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_sqrt #(
  parameter int unsigned IN_W   = 62,
  parameter int unsigned SIDE_W = 97
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [IN_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     valid_o,
  output logic [IN_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int unsigned STEPS = IN_W / 2;

  logic              v_q    [1:STEPS];
  logic [IN_W-1:0]   n_q    [1:STEPS];
  logic [IN_W-1:0]   r_q    [1:STEPS];
  logic [SIDE_W-1:0] side_q [1:STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int unsigned BP = 2 * (STEPS - 1 - j);

    logic              v_c;
    logic [IN_W-1:0]   n_c;
    logic [IN_W-1:0]   r_c;
    logic [SIDE_W-1:0] s_c;
    logic [IN_W-1:0]   bit_c;
    logic [IN_W:0]     trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_c = valid_i;
      assign n_c = rad_i;
      assign r_c = '0;
      assign s_c = side_i;
    end else begin : g_next
      assign v_c = v_q[j];
      assign n_c = n_q[j];
      assign r_c = r_q[j];
      assign s_c = side_q[j];
    end

    assign bit_c = {{(IN_W-1){1'b0}}, 1'b1} << BP;
    assign trial = {1'b0, r_c} + {1'b0, bit_c};
    assign ge    = {1'b0, n_c} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j+1]    <= ge ? (n_c - trial[IN_W-1:0]) : n_c;
        r_q[j+1]    <= ge ? ((r_c >> 1) + bit_c) : (r_c >> 1);
        side_q[j+1] <= s_c;
      end
    end
  end

  assign valid_o = v_q[STEPS];
  assign root_o  = r_q[STEPS][STEPS-1:0];
  assign side_o  = side_q[STEPS];

endmodule

`default_nettype wire

FILE: src/rff_div.sv
// ----------------------------------------------------------------------------
// rff_div: pipelined restoring divider
// Several numerators share one divisor; one quotient bit per stage. The
// quotient must fit in Q_W bits, which the caller guarantees.
// ----------------------------------------------------------------------------
`default_nettype none

module rff_div #(
  parameter int unsigned NUM_W  = 63,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned Q_W    = 32,
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 5
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]             den_i,
  input  wire logic [SIDE_W-1:0]            side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][Q_W-1:0]         quot_o,
  output logic [SIDE_W-1:0]                 side_o
);

  logic                        v_q    [1:Q_W];
  logic [LANES-1:0][NUM_W-1:0] rem_q  [1:Q_W];
  logic [LANES-1:0][Q_W-1:0]   q_q    [1:Q_W];
  logic [DEN_W-1:0]            den_q  [1:Q_W];
  logic [SIDE_W-1:0]           side_q [1:Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_step
    localparam int unsigned SH = Q_W - 1 - j;

    logic                        v_c;
    logic [LANES-1:0][NUM_W-1:0] rem_c;
    logic [LANES-1:0][Q_W-1:0]   q_c;
    logic [DEN_W-1:0]            den_c;
    logic [SIDE_W-1:0]           s_c;
    logic [NUM_W-1:0]            den_sh;
    logic [LANES-1:0][NUM_W-1:0] rem_d;
    logic [LANES-1:0][Q_W-1:0]   q_d;

    if (j == 0) begin : g_first
      assign v_c   = valid_i;
      assign rem_c = num_i;
      assign q_c   = '0;
      assign den_c = den_i;
      assign s_c   = side_i;
    end else begin : g_next
      assign v_c   = v_q[j];
      assign rem_c = rem_q[j];
      assign q_c   = q_q[j];
      assign den_c = den_q[j];
      assign s_c   = side_q[j];
    end

    assign den_sh = {{(NUM_W-DEN_W){1'b0}}, den_c} << SH;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_c[l] >= den_sh) begin
          rem_d[l] = rem_c[l] - den_sh;
          q_d[l]   = {q_c[l][Q_W-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_c[l];
          q_d[l]   = {q_c[l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= rem_d;
        q_q[j+1]    <= q_d;
        den_q[j+1]  <= den_c;
        side_q[j+1] <= s_c;
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = q_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

`default_nettype wire

FILE: src/radial_force_field.sv
// ----------------------------------------------------------------------------
// radial_force_field: radial attractor with linear falloff
// Computes, for each particle position, the force towards a configured centre
// scaled by peak_force*(radius-d)/radius inside the radius, zero outside.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   pos_i     in         valid/ready    particle_x, particle_y, particle_z
//   force_o   out        valid/ready    force_x, force_y, force_z, inside_res
//   cfg_*     in         write enable   cfg_idx_i, cfg_data_i
//
// One beat is accepted every cycle while the skid register is empty. Each
// result passes through a chain of a bit-per-stage square root and two
// bit-per-stage dividers. Reset clears the configuration and all valid bits.
// A stall at the output parks one beat in a skid register and freezes the
// whole pipeline until it is taken, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_force_field #(
  parameter int unsigned COORD_WIDTH = rff_pkg::COORD_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rff_pos_if.sink                            pos_i,
  rff_force_if.source                        force_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rff_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data_i
);

  localparam int unsigned W      = COORD_WIDTH;
  // Squared distances are twice the width of a magnitude below the radius.
  localparam int unsigned SUM_W  = 2 * (W - 1);
  // Products of a magnitude and a force, before the divisions.
  localparam int unsigned PROD_W = 2 * W - 1;
  localparam int unsigned SQ_SIDE = 3 * (W - 1) + 4;
  localparam int unsigned MD_SIDE = 4 * (W - 1) + 5;
  localparam int unsigned CD_SIDE = 5;

  // --------------------------------------------------------------------------
  // Configuration registers and the values derived from them. The derived
  // values are registered. The user must change configuration only while the
  // block is idle, as the block does not enforce it; then the delay is unseen.
  // --------------------------------------------------------------------------
  logic [W-1:0]     cx_q, cy_q, cz_q, peak_q;
  logic [W-2:0]     radius_q;
  logic [SUM_W-1:0] rsq_q;
  logic [W-1:0]     pmag_q;
  logic             peak_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      radius_q <= '0;
      peak_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (rff_pkg::cfg_reg_e'(cfg_idx_i))
        rff_pkg::REG_CENTER_X:   cx_q     <= cfg_data_i;
        rff_pkg::REG_CENTER_Y:   cy_q     <= cfg_data_i;
        rff_pkg::REG_CENTER_Z:   cz_q     <= cfg_data_i;
        rff_pkg::REG_RADIUS:     radius_q <= cfg_data_i[W-2:0];
        rff_pkg::REG_PEAK_FORCE: peak_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsq_q      <= '0;
      pmag_q     <= '0;
      peak_neg_q <= 1'b0;
    end else begin
      rsq_q      <= {{(W-1){1'b0}}, radius_q} * {{(W-1){1'b0}}, radius_q};
      // The most negative peak maps onto its own bit pattern, which read as
      // unsigned is exactly its magnitude.
      pmag_q     <= peak_q[W-1] ? (~peak_q + 1'b1) : peak_q;
      peak_neg_q <= peak_q[W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The pipeline advances whenever the skid register is empty.
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_v_q;

  assign adv         = !skid_v_q;
  assign pos_i.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: offsets from the particle to the centre, their magnitudes and
  // the coarse test against the radius on each axis.
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0] ctr, pos;
  logic [2:0][W:0]   diff, absd;
  logic [2:0]        near;
  logic [2:0][W-2:0] a1_d;
  logic [2:0]        neg1_d;
  logic              in1_d;

  assign ctr[0] = cx_q;
  assign ctr[1] = cy_q;
  assign ctr[2] = cz_q;
  assign pos[0] = pos_i.particle_x;
  assign pos[1] = pos_i.particle_y;
  assign pos[2] = pos_i.particle_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = {ctr[i][W-1], ctr[i]} - {pos[i][W-1], pos[i]};
      absd[i]   = diff[i][W] ? (~diff[i] + 1'b1) : diff[i];
      near[i]   = absd[i] < {2'b00, radius_q};
      a1_d[i]   = absd[i][W-2:0];
      neg1_d[i] = diff[i][W];
    end
    in1_d = (radius_q != '0) && (&near);
  end

  logic              v1_q, in1_q;
  logic [2:0][W-2:0] a1_q;
  logic [2:0]        neg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pos_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q   <= a1_d;
      neg1_q <= neg1_d;
      in1_q  <= in1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares of the three magnitudes.
  // --------------------------------------------------------------------------
  logic                v2_q, in2_q;
  logic [2:0][SUM_W-1:0] sq2_q;
  logic [2:0][W-2:0]   a2_q;
  logic [2:0]          neg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= {{(W-1){1'b0}}, a1_q[i]} * {{(W-1){1'b0}}, a1_q[i]};
      end
      a2_q   <= a1_q;
      neg2_q <= neg1_q;
      in2_q  <= in1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squared distance and the exact test against the squared radius.
  // --------------------------------------------------------------------------
  logic [SUM_W+1:0] sum_full;

  assign sum_full = {2'b00, sq2_q[0]} + {2'b00, sq2_q[1]} + {2'b00, sq2_q[2]};

  logic              v3_q, in3_q;
  logic [SUM_W-1:0]  sum3_q;
  logic [2:0][W-2:0] a3_q;
  logic [2:0]        neg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum3_q <= sum_full[SUM_W-1:0];
      in3_q  <= in2_q && (sum_full < {2'b00, rsq_q});
      a3_q   <= a2_q;
      neg3_q <= neg2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root: the distance, one bit per stage.
  // --------------------------------------------------------------------------
  logic              vr;
  logic [W-2:0]      dist_r;
  logic [2:0][W-2:0] a_r;
  logic [2:0]        neg_r;
  logic              in_r;

  rff_sqrt #(
    .IN_W   (SUM_W),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (sum3_q),
    .side_i  ({a3_q, neg3_q, in3_q}),
    .valid_o (vr),
    .root_o  (dist_r),
    .side_o  ({a_r, neg_r, in_r})
  );

  // --------------------------------------------------------------------------
  // Stage 4: |peak_force|*(radius-d). Inside the radius d is below radius,
  // so the difference never wraps.
  // --------------------------------------------------------------------------
  logic [W-2:0] rmd;

  assign rmd = radius_q - dist_r;

  logic                   v4_q, in4_q, zero4_q;
  logic [0:0][PROD_W-1:0] prod4_q;
  logic [2:0][W-2:0]      a4_q;
  logic [W-2:0]           dist4_q;
  logic [2:0]             neg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q[0] <= {{(W-1){1'b0}}, pmag_q} * {{W{1'b0}}, rmd};
      zero4_q    <= dist_r == '0;
      a4_q       <= a_r;
      dist4_q    <= dist_r;
      neg4_q     <= neg_r;
      in4_q      <= in_r;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude division by the radius. The quotient never exceeds the peak
  // magnitude, so it fits in W bits.
  // --------------------------------------------------------------------------
  logic              vm;
  logic [0:0][W-1:0] mag_m;
  logic [2:0][W-2:0] a_m;
  logic [W-2:0]      dist_m;
  logic [2:0]        neg_m;
  logic              in_m, zero_m;

  rff_div #(
    .NUM_W  (PROD_W),
    .DEN_W  (W - 1),
    .Q_W    (W),
    .LANES  (1),
    .SIDE_W (MD_SIDE)
  ) u_mag_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v4_q),
    .num_i   (prod4_q),
    .den_i   (radius_q),
    .side_i  ({a4_q, dist4_q, neg4_q, in4_q, zero4_q}),
    .valid_o (vm),
    .quot_o  (mag_m),
    .side_o  ({a_m, dist_m, neg_m, in_m, zero_m})
  );

  // --------------------------------------------------------------------------
  // Stage 5: per-axis products of the magnitude and the axis offset.
  // --------------------------------------------------------------------------
  logic                   v5_q, in5_q, zero5_q;
  logic [2:0][PROD_W-1:0] prod5_q;
  logic [W-2:0]           dist5_q;
  logic [2:0]             neg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= vm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod5_q[i] <= {{W{1'b0}}, a_m[i]} * {{(W-1){1'b0}}, mag_m[0]};
      end
      dist5_q <= dist_m;
      neg5_q  <= neg_m;
      in5_q   <= in_m;
      zero5_q <= zero_m;
    end
  end

  // --------------------------------------------------------------------------
  // Component division by the distance. No axis offset exceeds the distance,
  // so each quotient is at most the magnitude. A zero distance yields a
  // meaningless quotient, which the last stage discards.
  // --------------------------------------------------------------------------
  logic              vc;
  logic [2:0][W-1:0] f_c;
  logic [2:0]        neg_c;
  logic              in_c, zero_c;

  rff_div #(
    .NUM_W  (PROD_W),
    .DEN_W  (W - 1),
    .Q_W    (W),
    .LANES  (3),
    .SIDE_W (CD_SIDE)
  ) u_vec_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .num_i   (prod5_q),
    .den_i   (dist5_q),
    .side_i  ({neg5_q, in5_q, zero5_q}),
    .valid_o (vc),
    .quot_o  (f_c),
    .side_o  ({neg_c, in_c, zero_c})
  );

  // --------------------------------------------------------------------------
  // Stage 6: apply the sign and saturate. A magnitude never exceeds 2^(W-1),
  // so only the positive side can overflow.
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0] f6_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!in_c || zero_c || f_c[i] == '0) begin
        f6_d[i] = '0;
      end else if (neg_c[i] != peak_neg_q) begin
        f6_d[i] = ~f_c[i] + 1'b1;
      end else if (f_c[i][W-1]) begin
        f6_d[i] = {1'b0, {(W-1){1'b1}}};
      end else begin
        f6_d[i] = f_c[i];
      end
    end
  end

  logic              v6_q, in6_q;
  logic [2:0][W-1:0] f6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= vc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f6_q  <= f6_d;
      in6_q <= in_c;
    end
  end

  // --------------------------------------------------------------------------
  // Skid register. While it is empty the pipeline moves every cycle, so a
  // beat in the last stage that is not taken is parked here; the pipeline
  // then holds until the parked beat has gone.
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0] skid_f_q;
  logic              skid_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (force_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (v6_q && !force_o.ready) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_f_q  <= f6_q;
      skid_in_q <= in6_q;
    end
  end

  assign force_o.valid      = skid_v_q || v6_q;
  assign force_o.force_x    = skid_v_q ? skid_f_q[0] : f6_q[0];
  assign force_o.force_y    = skid_v_q ? skid_f_q[1] : f6_q[1];
  assign force_o.force_z    = skid_v_q ? skid_f_q[2] : f6_q[2];
  assign force_o.inside_res = skid_v_q ? skid_in_q : in6_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A particle outside the field never produces a force.
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_o.valid && !force_o.inside_res |->
      force_o.force_x == '0 && force_o.force_y == '0 && force_o.force_z == '0)
    else $error("nonzero force reported for a particle outside the field");

  // A beat in the last stage that is not taken must be parked.
  a_skid_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q && v6_q && !force_o.ready |=> skid_v_q)
    else $error("stalled result beat was not parked in the skid register");

  // A parked beat stays put until it is taken.
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !force_o.ready |=>
      skid_v_q && $stable(skid_f_q) && $stable(skid_in_q))
    else $error("parked result beat changed before it was taken");

endmodule

`default_nettype wire
